// ----- rtl/core/env_comp_pkg.sv -----
package env_comp_pkg;

   localparam int unsigned DataW   = 64;
   localparam int unsigned ValueW  = 32;
   localparam int unsigned RawW    = 20;
   localparam int unsigned FuncW   = 2;
   localparam int unsigned CsrIdxW = 3;
   localparam int unsigned PcW     = 6;
   localparam int unsigned ShW     = 6;
   localparam int unsigned DstW    = 3;

   // measurement selector
   typedef enum logic [FuncW-1:0] {
      FUNC_TEMP  = 2'd0,
      FUNC_PRESS = 2'd1,
      FUNC_HUM   = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   // calibration register indexes
   localparam logic [CsrIdxW-1:0] CSR_TEMP_CAL    = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_PRESS_CAL_A = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_PRESS_CAL_B = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_PRESS_CAL_C = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_HUM_CAL_A   = 3'd4;
   localparam logic [CsrIdxW-1:0] CSR_HUM_CAL_B   = 3'd5;

   // formula constants
   localparam logic [DataW-1:0] K_P_OFFSET = 64'd128000;
   localparam logic [DataW-1:0] K_P_BASE   = 64'd1048576;
   localparam logic [DataW-1:0] K_P_SCALE  = 64'd3125;
   localparam logic [DataW-1:0] K_P_ONE47  = 64'h0000_8000_0000_0000;
   localparam logic [DataW-1:0] K_H_OFFSET = 64'd76800;
   localparam logic [DataW-1:0] K_H_CAP    = 64'd419430400;
   localparam logic [DataW-1:0] K_H_BIAS   = 64'd2097152;
   localparam logic [DataW-1:0] K_H_ROUND1 = 64'd16384;
   localparam logic [DataW-1:0] K_H_ADD    = 64'd32768;
   localparam logic [DataW-1:0] K_H_ROUND2 = 64'd8192;
   localparam logic [DataW-1:0] K_T_MUL    = 64'd5;
   localparam logic [DataW-1:0] K_T_ROUND  = 64'd128;
   localparam logic [DataW-1:0] K_ZERO     = 64'd0;

   // working registers
   localparam logic [DstW-1:0] REG_0 = 3'd0;
   localparam logic [DstW-1:0] REG_1 = 3'd1;
   localparam logic [DstW-1:0] REG_2 = 3'd2;
   localparam logic [DstW-1:0] REG_3 = 3'd3;
   localparam logic [DstW-1:0] REG_4 = 3'd4;

   typedef enum logic [3:0] {
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_ASR, OP_SHL,
      OP_STF, OP_CHKZ, OP_CLAMP, OP_DONE
   } op_type;

   typedef enum logic [4:0] {
      SRC_R0, SRC_R1, SRC_R2, SRC_R3, SRC_R4,
      SRC_RAW, SRC_RAWH, SRC_FINE, SRC_IMM,
      SRC_T1, SRC_T2, SRC_T3,
      SRC_P1, SRC_P2, SRC_P3, SRC_P4, SRC_P5, SRC_P6, SRC_P7, SRC_P8, SRC_P9,
      SRC_H1, SRC_H2, SRC_H3, SRC_H4, SRC_H5, SRC_H6
   } src_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_EXEC, ST_MULW, ST_DIVW, ST_HOLD
   } state_type;

   typedef enum logic [1:0] {
      DIV_IDLE, DIV_ABS, DIV_ITER, DIV_FIX
   } div_state_type;

   typedef struct packed {
      op_type           op;
      logic [DstW-1:0]  dst;
      src_type          a;
      src_type          b;
      logic [ShW-1:0]   sh;
      logic [DataW-1:0] imm;
   } uop_type;

   function automatic uop_type mk(input op_type op, input logic [DstW-1:0] dst,
                                  input src_type a, input src_type b,
                                  input logic [ShW-1:0] sh,
                                  input logic [DataW-1:0] imm);
      uop_type u;
      u.op  = op;
      u.dst = dst;
      u.a   = a;
      u.b   = b;
      u.sh  = sh;
      u.imm = imm;
      return u;
   endfunction

   // temperature sequence, 32-bit mode
   function automatic uop_type temp_prog(input logic [PcW-1:0] pc);
      uop_type u;
      case (pc)
         6'd0:  u = mk(OP_ASR, REG_0, SRC_RAW, SRC_IMM, 6'd3, K_ZERO);
         6'd1:  u = mk(OP_SHL, REG_1, SRC_T1, SRC_IMM, 6'd1, K_ZERO);
         6'd2:  u = mk(OP_SUB, REG_0, SRC_R0, SRC_R1, 6'd0, K_ZERO);
         6'd3:  u = mk(OP_MUL, REG_0, SRC_R0, SRC_T2, 6'd0, K_ZERO);
         6'd4:  u = mk(OP_ASR, REG_0, SRC_R0, SRC_IMM, 6'd11, K_ZERO);
         6'd5:  u = mk(OP_ASR, REG_1, SRC_RAW, SRC_IMM, 6'd4, K_ZERO);
         6'd6:  u = mk(OP_SUB, REG_1, SRC_R1, SRC_T1, 6'd0, K_ZERO);
         6'd7:  u = mk(OP_MUL, REG_1, SRC_R1, SRC_R1, 6'd0, K_ZERO);
         6'd8:  u = mk(OP_ASR, REG_1, SRC_R1, SRC_IMM, 6'd12, K_ZERO);
         6'd9:  u = mk(OP_MUL, REG_1, SRC_R1, SRC_T3, 6'd0, K_ZERO);
         6'd10: u = mk(OP_ASR, REG_1, SRC_R1, SRC_IMM, 6'd14, K_ZERO);
         6'd11: u = mk(OP_ADD, REG_0, SRC_R0, SRC_R1, 6'd0, K_ZERO);
         6'd12: u = mk(OP_STF, REG_0, SRC_R0, SRC_IMM, 6'd0, K_ZERO);
         6'd13: u = mk(OP_MUL, REG_0, SRC_R0, SRC_IMM, 6'd0, K_T_MUL);
         6'd14: u = mk(OP_ADD, REG_0, SRC_R0, SRC_IMM, 6'd0, K_T_ROUND);
         6'd15: u = mk(OP_ASR, REG_0, SRC_R0, SRC_IMM, 6'd8, K_ZERO);
         default: u = mk(OP_DONE, REG_0, SRC_R0, SRC_IMM, 6'd0, K_ZERO);
      endcase
      return u;
   endfunction

   // pressure sequence, 64-bit mode
   function automatic uop_type press_prog(input logic [PcW-1:0] pc);
      uop_type u;
      case (pc)
         6'd0:  u = mk(OP_SUB, REG_0, SRC_FINE, SRC_IMM, 6'd0, K_P_OFFSET);
         6'd1:  u = mk(OP_MUL, REG_1, SRC_R0, SRC_R0, 6'd0, K_ZERO);
         6'd2:  u = mk(OP_MUL, REG_2, SRC_R1, SRC_P6, 6'd0, K_ZERO);
         6'd3:  u = mk(OP_MUL, REG_3, SRC_R0, SRC_P5, 6'd0, K_ZERO);
         6'd4:  u = mk(OP_SHL, REG_3, SRC_R3, SRC_IMM, 6'd17, K_ZERO);
         6'd5:  u = mk(OP_ADD, REG_2, SRC_R2, SRC_R3, 6'd0, K_ZERO);
         6'd6:  u = mk(OP_SHL, REG_3, SRC_P4, SRC_IMM, 6'd35, K_ZERO);
         6'd7:  u = mk(OP_ADD, REG_2, SRC_R2, SRC_R3, 6'd0, K_ZERO);
         6'd8:  u = mk(OP_MUL, REG_1, SRC_R1, SRC_P3, 6'd0, K_ZERO);
         6'd9:  u = mk(OP_ASR, REG_1, SRC_R1, SRC_IMM, 6'd8, K_ZERO);
         6'd10: u = mk(OP_MUL, REG_3, SRC_R0, SRC_P2, 6'd0, K_ZERO);
         6'd11: u = mk(OP_SHL, REG_3, SRC_R3, SRC_IMM, 6'd12, K_ZERO);
         6'd12: u = mk(OP_ADD, REG_0, SRC_R1, SRC_R3, 6'd0, K_ZERO);
         6'd13: u = mk(OP_ADD, REG_0, SRC_R0, SRC_IMM, 6'd0, K_P_ONE47);
         6'd14: u = mk(OP_MUL, REG_0, SRC_R0, SRC_P1, 6'd0, K_ZERO);
         6'd15: u = mk(OP_ASR, REG_0, SRC_R0, SRC_IMM, 6'd33, K_ZERO);
         6'd16: u = mk(OP_CHKZ, REG_0, SRC_R0, SRC_IMM, 6'd0, K_ZERO);
         6'd17: u = mk(OP_SUB, REG_1, SRC_IMM, SRC_RAW, 6'd0, K_P_BASE);
         6'd18: u = mk(OP_SHL, REG_1, SRC_R1, SRC_IMM, 6'd31, K_ZERO);
         6'd19: u = mk(OP_SUB, REG_1, SRC_R1, SRC_R2, 6'd0, K_ZERO);
         6'd20: u = mk(OP_MUL, REG_1, SRC_R1, SRC_IMM, 6'd0, K_P_SCALE);
         6'd21: u = mk(OP_DIV, REG_1, SRC_R1, SRC_R0, 6'd0, K_ZERO);
         6'd22: u = mk(OP_ASR, REG_2, SRC_R1, SRC_IMM, 6'd13, K_ZERO);
         6'd23: u = mk(OP_MUL, REG_3, SRC_P9, SRC_R2, 6'd0, K_ZERO);
         6'd24: u = mk(OP_MUL, REG_3, SRC_R3, SRC_R2, 6'd0, K_ZERO);
         6'd25: u = mk(OP_ASR, REG_3, SRC_R3, SRC_IMM, 6'd25, K_ZERO);
         6'd26: u = mk(OP_MUL, REG_4, SRC_P8, SRC_R1, 6'd0, K_ZERO);
         6'd27: u = mk(OP_ASR, REG_4, SRC_R4, SRC_IMM, 6'd19, K_ZERO);
         6'd28: u = mk(OP_ADD, REG_1, SRC_R1, SRC_R3, 6'd0, K_ZERO);
         6'd29: u = mk(OP_ADD, REG_1, SRC_R1, SRC_R4, 6'd0, K_ZERO);
         6'd30: u = mk(OP_ASR, REG_1, SRC_R1, SRC_IMM, 6'd8, K_ZERO);
         6'd31: u = mk(OP_SHL, REG_3, SRC_P7, SRC_IMM, 6'd4, K_ZERO);
         6'd32: u = mk(OP_ADD, REG_1, SRC_R1, SRC_R3, 6'd0, K_ZERO);
         default: u = mk(OP_DONE, REG_1, SRC_R1, SRC_IMM, 6'd0, K_ZERO);
      endcase
      return u;
   endfunction

   // humidity sequence, 32-bit mode
   function automatic uop_type hum_prog(input logic [PcW-1:0] pc);
      uop_type u;
      case (pc)
         6'd0:  u = mk(OP_SUB, REG_0, SRC_FINE, SRC_IMM, 6'd0, K_H_OFFSET);
         6'd1:  u = mk(OP_SHL, REG_1, SRC_RAWH, SRC_IMM, 6'd14, K_ZERO);
         6'd2:  u = mk(OP_SHL, REG_2, SRC_H4, SRC_IMM, 6'd20, K_ZERO);
         6'd3:  u = mk(OP_SUB, REG_1, SRC_R1, SRC_R2, 6'd0, K_ZERO);
         6'd4:  u = mk(OP_MUL, REG_2, SRC_H5, SRC_R0, 6'd0, K_ZERO);
         6'd5:  u = mk(OP_SUB, REG_1, SRC_R1, SRC_R2, 6'd0, K_ZERO);
         6'd6:  u = mk(OP_ADD, REG_1, SRC_R1, SRC_IMM, 6'd0, K_H_ROUND1);
         6'd7:  u = mk(OP_ASR, REG_1, SRC_R1, SRC_IMM, 6'd15, K_ZERO);
         6'd8:  u = mk(OP_MUL, REG_2, SRC_R0, SRC_H6, 6'd0, K_ZERO);
         6'd9:  u = mk(OP_ASR, REG_2, SRC_R2, SRC_IMM, 6'd10, K_ZERO);
         6'd10: u = mk(OP_MUL, REG_3, SRC_R0, SRC_H3, 6'd0, K_ZERO);
         6'd11: u = mk(OP_ASR, REG_3, SRC_R3, SRC_IMM, 6'd11, K_ZERO);
         6'd12: u = mk(OP_ADD, REG_3, SRC_R3, SRC_IMM, 6'd0, K_H_ADD);
         6'd13: u = mk(OP_MUL, REG_2, SRC_R2, SRC_R3, 6'd0, K_ZERO);
         6'd14: u = mk(OP_ASR, REG_2, SRC_R2, SRC_IMM, 6'd10, K_ZERO);
         6'd15: u = mk(OP_ADD, REG_2, SRC_R2, SRC_IMM, 6'd0, K_H_BIAS);
         6'd16: u = mk(OP_MUL, REG_2, SRC_R2, SRC_H2, 6'd0, K_ZERO);
         6'd17: u = mk(OP_ADD, REG_2, SRC_R2, SRC_IMM, 6'd0, K_H_ROUND2);
         6'd18: u = mk(OP_ASR, REG_2, SRC_R2, SRC_IMM, 6'd14, K_ZERO);
         6'd19: u = mk(OP_MUL, REG_1, SRC_R1, SRC_R2, 6'd0, K_ZERO);
         6'd20: u = mk(OP_ASR, REG_2, SRC_R1, SRC_IMM, 6'd15, K_ZERO);
         6'd21: u = mk(OP_MUL, REG_2, SRC_R2, SRC_R2, 6'd0, K_ZERO);
         6'd22: u = mk(OP_ASR, REG_2, SRC_R2, SRC_IMM, 6'd7, K_ZERO);
         6'd23: u = mk(OP_MUL, REG_2, SRC_R2, SRC_H1, 6'd0, K_ZERO);
         6'd24: u = mk(OP_ASR, REG_2, SRC_R2, SRC_IMM, 6'd4, K_ZERO);
         6'd25: u = mk(OP_SUB, REG_1, SRC_R1, SRC_R2, 6'd0, K_ZERO);
         6'd26: u = mk(OP_CLAMP, REG_1, SRC_R1, SRC_IMM, 6'd0, K_H_CAP);
         6'd27: u = mk(OP_ASR, REG_1, SRC_R1, SRC_IMM, 6'd12, K_ZERO);
         default: u = mk(OP_DONE, REG_1, SRC_R1, SRC_IMM, 6'd0, K_ZERO);
      endcase
      return u;
   endfunction

endpackage

// ----- rtl/core/env_comp_req_if.sv -----
interface env_comp_req_if;
   logic                              valid;
   logic                              ready;
   logic [env_comp_pkg::FuncW-1:0]    func;
   logic [env_comp_pkg::RawW-1:0]     raw_reading;

   modport source (output valid, func, raw_reading, input ready);
   modport sink   (input valid, func, raw_reading, output ready);
endinterface

// ----- rtl/core/env_comp_rsp_if.sv -----
interface env_comp_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [env_comp_pkg::ValueW-1:0]   value;
   logic                              divide_by_zero;

   modport source (output valid, value, divide_by_zero, input ready);
   modport sink   (input valid, value, divide_by_zero, output ready);
endinterface

// ----- rtl/core/env_comp_csr_if.sv -----
interface env_comp_csr_if;
   logic                              valid;
   logic                              ready;
   logic [env_comp_pkg::CsrIdxW-1:0]  index;
   logic [env_comp_pkg::DataW-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/env_sensor_compensation_core.sv -----
// A multiply runs longer the more radix-4 digits its second operand has; the divide
// never stops early. Pressure ends early on a zero divisor; selector three returns
// zero without running a sequence. Output stalls lengthen the time to a result.
// Throughput: one word at a time; a new word is taken once the previous result
// has moved to the output register. Shared multiplier and divider set the rate.
// Reset: synchronous; clears calibration, fine temperature and control state.
module env_sensor_compensation_core (
   input  logic            clock,
   input  logic            reset,
   env_comp_csr_if.sink    csr_if,
   env_comp_req_if.sink    req_if,
   env_comp_rsp_if.source  rsp_if
);

   localparam int unsigned W  = env_comp_pkg::DataW;
   localparam int unsigned VW = env_comp_pkg::ValueW;

   // calibration registers
   logic [47:0] temp_cal_ff;
   logic [63:0] press_cal_a_ff;
   logic [63:0] press_cal_b_ff;
   logic [15:0] press_cal_c_ff;
   logic [31:0] hum_cal_a_ff;
   logic [39:0] hum_cal_b_ff;

   env_comp_pkg::state_type state_ff;
   env_comp_pkg::state_type state_in;
   env_comp_pkg::func_type  kind_ff;
   env_comp_pkg::uop_type   uop;
   logic [env_comp_pkg::PcW-1:0]  pc_ff;
   logic [env_comp_pkg::PcW-1:0]  pc_in;
   logic [env_comp_pkg::RawW-1:0] raw_ff;
   logic [VW-1:0] fine_ff;
   logic [W-1:0]  r0_ff, r1_ff, r2_ff, r3_ff, r4_ff;
   logic [W-1:0]  opa, opb, alu_res, wr_data;
   logic          w32;
   logic          wr_en, fine_we, mul_start, div_start, load_out, req_ready;
   logic          mul_done, div_done;
   logic [W-1:0]  mul_prod, div_quot;
   logic [VW-1:0] pend_val_ff, pend_val_in;
   logic          pend_dz_ff, pend_dz_in;
   logic          rsp_valid_ff;
   logic [VW-1:0] rsp_value_ff;
   logic          rsp_dz_ff;

   function automatic logic [W-1:0] sx16(input logic [15:0] x);
      return {{(W-16){x[15]}}, x};
   endfunction

   // operand source mux
   function automatic logic [W-1:0] pick(input env_comp_pkg::src_type s);
      logic [W-1:0] v;
      case (s)
         env_comp_pkg::SRC_R0:   v = r0_ff;
         env_comp_pkg::SRC_R1:   v = r1_ff;
         env_comp_pkg::SRC_R2:   v = r2_ff;
         env_comp_pkg::SRC_R3:   v = r3_ff;
         env_comp_pkg::SRC_R4:   v = r4_ff;
         env_comp_pkg::SRC_RAW:  v = {{(W-env_comp_pkg::RawW){1'b0}}, raw_ff};
         env_comp_pkg::SRC_RAWH: v = {{(W-16){1'b0}}, raw_ff[15:0]};
         env_comp_pkg::SRC_FINE: v = {{(W-VW){fine_ff[VW-1]}}, fine_ff};
         env_comp_pkg::SRC_IMM:  v = uop.imm;
         env_comp_pkg::SRC_T1:   v = {{(W-16){1'b0}}, temp_cal_ff[15:0]};
         env_comp_pkg::SRC_T2:   v = sx16(temp_cal_ff[31:16]);
         env_comp_pkg::SRC_T3:   v = sx16(temp_cal_ff[47:32]);
         env_comp_pkg::SRC_P1:   v = {{(W-16){1'b0}}, press_cal_a_ff[15:0]};
         env_comp_pkg::SRC_P2:   v = sx16(press_cal_a_ff[31:16]);
         env_comp_pkg::SRC_P3:   v = sx16(press_cal_a_ff[47:32]);
         env_comp_pkg::SRC_P4:   v = sx16(press_cal_a_ff[63:48]);
         env_comp_pkg::SRC_P5:   v = sx16(press_cal_b_ff[15:0]);
         env_comp_pkg::SRC_P6:   v = sx16(press_cal_b_ff[31:16]);
         env_comp_pkg::SRC_P7:   v = sx16(press_cal_b_ff[47:32]);
         env_comp_pkg::SRC_P8:   v = sx16(press_cal_b_ff[63:48]);
         env_comp_pkg::SRC_P9:   v = sx16(press_cal_c_ff);
         env_comp_pkg::SRC_H1:   v = {{(W-8){1'b0}}, hum_cal_a_ff[7:0]};
         env_comp_pkg::SRC_H2:   v = sx16(hum_cal_a_ff[23:8]);
         env_comp_pkg::SRC_H3:   v = {{(W-8){1'b0}}, hum_cal_a_ff[31:24]};
         env_comp_pkg::SRC_H4:   v = sx16(hum_cal_b_ff[15:0]);
         env_comp_pkg::SRC_H5:   v = sx16(hum_cal_b_ff[31:16]);
         env_comp_pkg::SRC_H6:   v = {{(W-8){hum_cal_b_ff[39]}}, hum_cal_b_ff[39:32]};
         default:                v = '0;
      endcase
      return v;
   endfunction

   // current step of the selected sequence
   always_comb begin
      case (kind_ff)
         env_comp_pkg::FUNC_TEMP:  uop = env_comp_pkg::temp_prog(pc_ff);
         env_comp_pkg::FUNC_PRESS: uop = env_comp_pkg::press_prog(pc_ff);
         default:                  uop = env_comp_pkg::hum_prog(pc_ff);
      endcase
   end

   // operands follow the working registers as well as the step
   always_comb begin
      opa = pick(uop.a);
      opb = pick(uop.b);
   end

   assign w32 = (kind_ff != env_comp_pkg::FUNC_PRESS);

   // 32-bit formulas keep values sign-extended from bit 31
   assign wr_data = w32 ? {{(W-VW){alu_res[VW-1]}}, alu_res[VW-1:0]} : alu_res;

   // sequencer
   always_comb begin
      state_in    = state_ff;
      pc_in       = pc_ff;
      alu_res     = '0;
      wr_en       = 1'b0;
      fine_we     = 1'b0;
      mul_start   = 1'b0;
      div_start   = 1'b0;
      load_out    = 1'b0;
      req_ready   = 1'b0;
      pend_val_in = pend_val_ff;
      pend_dz_in  = pend_dz_ff;
      case (state_ff)
         env_comp_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_if.valid) begin
               pc_in = '0;
               if (env_comp_pkg::func_type'(req_if.func) == env_comp_pkg::FUNC_NONE) begin
                  pend_val_in = '0;
                  pend_dz_in  = 1'b0;
                  state_in    = env_comp_pkg::ST_HOLD;
               end else begin
                  state_in = env_comp_pkg::ST_EXEC;
               end
            end
         end
         env_comp_pkg::ST_EXEC: begin
            pc_in = pc_ff + 1'b1;
            case (uop.op)
               env_comp_pkg::OP_ADD: begin
                  alu_res = opa + opb;
                  wr_en   = 1'b1;
               end
               env_comp_pkg::OP_SUB: begin
                  alu_res = opa - opb;
                  wr_en   = 1'b1;
               end
               env_comp_pkg::OP_ASR: begin
                  alu_res = W'($signed(opa) >>> uop.sh);
                  wr_en   = 1'b1;
               end
               env_comp_pkg::OP_SHL: begin
                  alu_res = opa << uop.sh;
                  wr_en   = 1'b1;
               end
               env_comp_pkg::OP_MUL: begin
                  mul_start = 1'b1;
                  pc_in     = pc_ff;
                  state_in  = env_comp_pkg::ST_MULW;
               end
               env_comp_pkg::OP_DIV: begin
                  div_start = 1'b1;
                  pc_in     = pc_ff;
                  state_in  = env_comp_pkg::ST_DIVW;
               end
               env_comp_pkg::OP_STF: fine_we = 1'b1;
               env_comp_pkg::OP_CHKZ: begin
                  if (opa == '0) begin
                     pend_val_in = '0;
                     pend_dz_in  = 1'b1;
                     state_in    = env_comp_pkg::ST_HOLD;
                  end
               end
               env_comp_pkg::OP_CLAMP: begin
                  wr_en = 1'b1;
                  if (opa[W-1]) begin
                     alu_res = '0;
                  end else if ($signed(opa) > $signed(opb)) begin
                     alu_res = opb;
                  end else begin
                     alu_res = opa;
                  end
               end
               env_comp_pkg::OP_DONE: begin
                  pend_val_in = opa[VW-1:0];
                  pend_dz_in  = 1'b0;
                  state_in    = env_comp_pkg::ST_HOLD;
               end
               default: state_in = env_comp_pkg::ST_IDLE;
            endcase
         end
         env_comp_pkg::ST_MULW: begin
            if (mul_done) begin
               alu_res  = mul_prod;
               wr_en    = 1'b1;
               pc_in    = pc_ff + 1'b1;
               state_in = env_comp_pkg::ST_EXEC;
            end
         end
         env_comp_pkg::ST_DIVW: begin
            if (div_done) begin
               alu_res  = div_quot;
               wr_en    = 1'b1;
               pc_in    = pc_ff + 1'b1;
               state_in = env_comp_pkg::ST_EXEC;
            end
         end
         env_comp_pkg::ST_HOLD: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               load_out = 1'b1;
               state_in = env_comp_pkg::ST_IDLE;
            end
         end
         default: state_in = env_comp_pkg::ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= env_comp_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         fine_ff      <= '0;
      end else begin
         state_ff <= state_in;
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (fine_we) fine_ff <= opa[VW-1:0];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pc_ff       <= pc_in;
      pend_val_ff <= pend_val_in;
      pend_dz_ff  <= pend_dz_in;
      if (req_ready && req_if.valid) begin
         kind_ff <= env_comp_pkg::func_type'(req_if.func);
         raw_ff  <= req_if.raw_reading;
      end
      if (load_out) begin
         rsp_value_ff <= pend_val_ff;
         rsp_dz_ff    <= pend_dz_ff;
      end
      if (wr_en) begin
         case (uop.dst)
            env_comp_pkg::REG_0: r0_ff <= wr_data;
            env_comp_pkg::REG_1: r1_ff <= wr_data;
            env_comp_pkg::REG_2: r2_ff <= wr_data;
            env_comp_pkg::REG_3: r3_ff <= wr_data;
            env_comp_pkg::REG_4: r4_ff <= wr_data;
            default: ;
         endcase
      end
   end

   // calibration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         temp_cal_ff    <= '0;
         press_cal_a_ff <= '0;
         press_cal_b_ff <= '0;
         press_cal_c_ff <= '0;
         hum_cal_a_ff   <= '0;
         hum_cal_b_ff   <= '0;
      end else if (csr_if.valid) begin
         case (csr_if.index)
            env_comp_pkg::CSR_TEMP_CAL:    temp_cal_ff    <= csr_if.data[47:0];
            env_comp_pkg::CSR_PRESS_CAL_A: press_cal_a_ff <= csr_if.data;
            env_comp_pkg::CSR_PRESS_CAL_B: press_cal_b_ff <= csr_if.data;
            env_comp_pkg::CSR_PRESS_CAL_C: press_cal_c_ff <= csr_if.data[15:0];
            env_comp_pkg::CSR_HUM_CAL_A:   hum_cal_a_ff   <= csr_if.data[31:0];
            env_comp_pkg::CSR_HUM_CAL_B:   hum_cal_b_ff   <= csr_if.data[39:0];
            default: ;
         endcase
      end
   end

   env_comp_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (opa),
      .b       (opb),
      .done    (mul_done),
      .product (mul_prod)
   );

   env_comp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .n        (opa),
      .d        (opb),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign csr_if.ready          = 1'b1;
   assign req_if.ready          = req_ready;
   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.value          = rsp_value_ff;
   assign rsp_if.divide_by_zero = rsp_dz_ff;

`ifndef ASSERT_OFF
   ap_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready |=> state_ff != env_comp_pkg::ST_IDLE)
      else $error("accepted word did not start work");
   ap_mul_done_waited: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> state_ff == env_comp_pkg::ST_MULW)
      else $error("multiplier finished with no step waiting");
   ap_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == env_comp_pkg::ST_DIVW)
      else $error("divider finished with no step waiting");
   ap_dz_zero_value: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.divide_by_zero |-> rsp_if.value == '0)
      else $error("zero divisor flag with nonzero value");
   ap_fine_temp_only: assert property (@(posedge clock) disable iff (reset)
      fine_we |-> kind_ff == env_comp_pkg::FUNC_TEMP)
      else $error("fine temperature written outside a temperature word");
`endif

endmodule

// ----- rtl/core/env_comp_mul.sv -----
// Radix-4 shift-add multiplier, low 64 bits of the product.
// Retires two multiplier bits per cycle, stops once the remaining bits are zero.
module env_comp_mul (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [env_comp_pkg::DataW-1:0]  a,
   input  logic [env_comp_pkg::DataW-1:0]  b,
   output logic                            done,
   output logic [env_comp_pkg::DataW-1:0]  product
);

   logic                            busy_ff;
   logic                            prep_ff;
   logic                            done_ff;
   logic [env_comp_pkg::DataW-1:0]  a1_ff;
   logic [env_comp_pkg::DataW-1:0]  a3_ff;
   logic [env_comp_pkg::DataW-1:0]  b_ff;
   logic [env_comp_pkg::DataW-1:0]  acc_ff;
   logic [env_comp_pkg::DataW-1:0]  digit;

   // multiple of a picked by the current digit
   always_comb begin
      case (b_ff[1:0])
         2'd0:    digit = '0;
         2'd1:    digit = a1_ff;
         2'd2:    digit = {a1_ff[env_comp_pkg::DataW-2:0], 1'b0};
         default: digit = a3_ff;
      endcase
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         prep_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            prep_ff <= 1'b1;
         end else if (busy_ff) begin
            if (prep_ff) begin
               prep_ff <= 1'b0;
            end else if (b_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         a1_ff  <= a;
         b_ff   <= b;
         acc_ff <= '0;
      end else if (busy_ff) begin
         if (prep_ff) begin
            a3_ff <= a1_ff + {a1_ff[env_comp_pkg::DataW-2:0], 1'b0};
         end else if (b_ff != '0) begin
            acc_ff <= acc_ff + digit;
            a1_ff  <= {a1_ff[env_comp_pkg::DataW-3:0], 2'b00};
            a3_ff  <= {a3_ff[env_comp_pkg::DataW-3:0], 2'b00};
            b_ff   <= {2'b00, b_ff[env_comp_pkg::DataW-1:2]};
         end
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// ----- rtl/core/env_comp_div.sv -----
// Signed 64-bit divider, truncating toward zero, one quotient bit per cycle.
// Divisor must be nonzero.
module env_comp_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [env_comp_pkg::DataW-1:0]  n,
   input  logic [env_comp_pkg::DataW-1:0]  d,
   output logic                            done,
   output logic [env_comp_pkg::DataW-1:0]  quotient
);

   localparam int unsigned W = env_comp_pkg::DataW;

   env_comp_pkg::div_state_type state_ff;
   env_comp_pkg::div_state_type state_in;
   logic                  done_ff;
   logic                  neg_ff;
   logic [$clog2(W)-1:0]  cnt_ff;
   logic [W-1:0]          n_ff;
   logic [W-1:0]          d_ff;
   logic [W-1:0]          rem_ff;
   logic [W-1:0]          quot_ff;
   logic [W:0]            rem_sh;
   logic [W:0]            rem_sub;
   logic                  qbit;

   // restoring step
   assign rem_sh  = {rem_ff, n_ff[W-1]};
   assign rem_sub = rem_sh - {1'b0, d_ff};
   assign qbit    = ~rem_sub[W];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         env_comp_pkg::DIV_IDLE: if (start) state_in = env_comp_pkg::DIV_ABS;
         env_comp_pkg::DIV_ABS:  state_in = env_comp_pkg::DIV_ITER;
         env_comp_pkg::DIV_ITER: if (cnt_ff == $clog2(W)'(W - 1)) begin
            state_in = env_comp_pkg::DIV_FIX;
         end
         env_comp_pkg::DIV_FIX:  state_in = env_comp_pkg::DIV_IDLE;
         default:                state_in = env_comp_pkg::DIV_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= env_comp_pkg::DIV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= (state_ff == env_comp_pkg::DIV_FIX);
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         env_comp_pkg::DIV_IDLE: begin
            if (start) begin
               n_ff   <= n;
               d_ff   <= d;
               neg_ff <= n[W-1] ^ d[W-1];
            end
         end
         env_comp_pkg::DIV_ABS: begin
            n_ff   <= n_ff[W-1] ? (~n_ff + 1'b1) : n_ff;
            d_ff   <= d_ff[W-1] ? (~d_ff + 1'b1) : d_ff;
            rem_ff <= '0;
            cnt_ff <= '0;
         end
         env_comp_pkg::DIV_ITER: begin
            rem_ff <= qbit ? rem_sub[W-1:0] : rem_sh[W-1:0];
            n_ff   <= {n_ff[W-2:0], qbit};
            cnt_ff <= cnt_ff + 1'b1;
         end
         env_comp_pkg::DIV_FIX: begin
            quot_ff <= neg_ff ? (~n_ff + 1'b1) : n_ff;
         end
         default: ;
      endcase
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

// ----- sim/env_sensor_compensation_core_test.sv -----
module env_sensor_compensation_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 1'b0;
   logic reset = 1'b1;

   env_comp_csr_if csr_if ();
   env_comp_req_if req_if ();
   env_comp_rsp_if rsp_if ();

   env_sensor_compensation_core dut (
      .clock(clock), .reset(reset),
      .csr_if(csr_if.sink), .req_if(req_if.sink),
      .rsp_if(rsp_if.source)
   );

   // clock, 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   typedef struct {
      logic [31:0] value;
      logic        dz;
   } comp_result_type;

   // shadow calibration and fine-temperature state
   logic [47:0] sh_temp_cal;
   logic [63:0] sh_press_a, sh_press_b;
   logic [15:0] sh_press_c;
   logic [31:0] sh_hum_a;
   logic [39:0] sh_hum_b;
   logic [31:0] sh_fine;

   comp_result_type expected_q[$];
   int errors = 0;
   int sent = 0;
   int received = 0;
   int cycles = 0;
   int n_temp = 0, n_press = 0, n_hum = 0, n_none = 0, n_dz = 0;
   logic rsp_stall_en = 1'b1;

   function automatic logic [31:0] sx16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   function automatic logic [63:0] sx16w(input logic [15:0] v);
      return {{48{v[15]}}, v};
   endfunction

   // arithmetic right shifts kept apart from unsigned terms
   function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned n);
      return $signed(x) >>> n;
   endfunction

   function automatic logic [63:0] asr64(input logic [63:0] x, input int unsigned n);
      return $signed(x) >>> n;
   endfunction

   function automatic logic [31:0] comp_temp(input logic [19:0] raw);
      logic [31:0] t1, t2, t3, x, v1, y, v2;
      t1 = {16'd0, sh_temp_cal[15:0]};
      t2 = sx16(sh_temp_cal[31:16]);
      t3 = sx16(sh_temp_cal[47:32]);
      x  = ({12'd0, raw} >> 3) - (t1 << 1);
      v1 = asr32(x * t2, 11);
      y  = ({12'd0, raw} >> 4) - t1;
      v2 = asr32(asr32(y * y, 12) * t3, 14);
      sh_fine = v1 + v2;
      return asr32(sh_fine * 32'd5 + 32'd128, 8);
   endfunction

   function automatic logic [63:0] sdiv(input logic [63:0] n, input logic [63:0] d);
      logic [63:0] mn, md, q;
      mn = n[63] ? -n : n;
      md = d[63] ? -d : d;
      q  = mn / md;
      return (n[63] != d[63]) ? -q : q;
   endfunction

   function automatic logic [31:0] comp_press(input logic [19:0] raw, output logic dz);
      logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, p, s;
      p1 = {48'd0, sh_press_a[15:0]};
      p2 = sx16w(sh_press_a[31:16]);
      p3 = sx16w(sh_press_a[47:32]);
      p4 = sx16w(sh_press_a[63:48]);
      p5 = sx16w(sh_press_b[15:0]);
      p6 = sx16w(sh_press_b[31:16]);
      p7 = sx16w(sh_press_b[47:32]);
      p8 = sx16w(sh_press_b[63:48]);
      p9 = sx16w(sh_press_c);
      dz = 1'b0;
      v1 = {{32{sh_fine[31]}}, sh_fine} - 64'd128000;
      v2 = v1 * v1 * p6;
      v2 = v2 + ((v1 * p5) << 17);
      v2 = v2 + (p4 << 35);
      v1 = asr64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
      v1 = asr64(((64'd1 << 47) + v1) * p1, 33);
      if (v1 == 64'd0) begin
         dz = 1'b1;
         return 32'd0;
      end
      p = 64'd1048576 - {44'd0, raw};
      p = sdiv(((p << 31) - v2) * 64'd3125, v1);
      s = asr64(p, 13);
      v1 = asr64(p9 * s * s, 25);
      v2 = asr64(p8 * p, 19);
      p = asr64(p + v1 + v2, 8) + (p7 << 4);
      return p[31:0];
   endfunction

   function automatic logic [31:0] comp_hum(input logic [19:0] raw);
      logic [31:0] h1, h2, h3, h4, h5, h6, h, v, a, i1, i2, t, b, s;
      h1 = {24'd0, sh_hum_a[7:0]};
      h2 = sx16(sh_hum_a[23:8]);
      h3 = {24'd0, sh_hum_a[31:24]};
      h4 = sx16(sh_hum_b[15:0]);
      h5 = sx16(sh_hum_b[31:16]);
      h6 = {{24{sh_hum_b[39]}}, sh_hum_b[39:32]};
      h  = {16'd0, raw[15:0]};
      v  = sh_fine - 32'd76800;
      a  = asr32((h << 14) - (h4 << 20) - h5 * v + 32'd16384, 15);
      i1 = asr32(v * h6, 10);
      i2 = asr32(v * h3, 11) + 32'd32768;
      t  = asr32(i1 * i2, 10) + 32'd2097152;
      b  = asr32(t * h2 + 32'd8192, 14);
      v  = a * b;
      s  = asr32(v, 15);
      v  = v - asr32(asr32(s * s, 7) * h1, 4);
      if (v[31]) v = 32'd0;
      else if (v > 32'd419430400) v = 32'd419430400;
      return v >> 12;
   endfunction

   function automatic comp_result_type compensate(input env_comp_pkg::func_type f,
                                                  input logic [19:0] raw);
      comp_result_type r;
      logic dz;
      r.dz = 1'b0;
      r.value = 32'd0;
      case (f)
         env_comp_pkg::FUNC_TEMP:  r.value = comp_temp(raw);
         env_comp_pkg::FUNC_PRESS: begin
            r.value = comp_press(raw, dz);
            r.dz = dz;
         end
         env_comp_pkg::FUNC_HUM:   r.value = comp_hum(raw);
         default:                  r.value = 32'd0;
      endcase
      return r;
   endfunction

   // initial drive
   initial begin
      req_if.valid = 1'b0;
      req_if.func = env_comp_pkg::FUNC_TEMP;
      req_if.raw_reading = '0;
      csr_if.valid = 1'b0;
      csr_if.index = env_comp_pkg::CSR_TEMP_CAL;
      csr_if.data = '0;
      rsp_if.ready = 1'b0;
   end

   // cycle limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 1500000) begin
         $display("%0t timeout, %0d results outstanding", $time, expected_q.size());
         $display("[env_sensor_compensation_core] ERROR");
         $finish;
      end
   end

   // result side: random ready and checking
   int rsp_wait = 0;
   always @(posedge clock) begin
      comp_result_type e;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            received++;
            if (expected_q.size() == 0) begin
               $display("%0t unexpected result value=%h dz=%b", $time,
                        rsp_if.value, rsp_if.divide_by_zero);
               errors++;
            end else begin
               e = expected_q.pop_front();
               if (rsp_if.value !== e.value) begin
                  $display("%0t value mismatch: expected %h actual %h", $time,
                           e.value, rsp_if.value);
                  errors++;
               end
               if (rsp_if.divide_by_zero !== e.dz) begin
                  $display("%0t divide_by_zero mismatch: expected %b actual %b",
                           $time, e.dz, rsp_if.divide_by_zero);
                  errors++;
               end
            end
         end
         if (rsp_wait > 0) begin
            rsp_wait <= rsp_wait - 1;
            rsp_if.ready <= 1'b0;
         end else if (rsp_if.valid && rsp_if.ready) begin
            if (rsp_stall_en && $urandom_range(1, 0) == 1) begin
               rsp_wait <= $urandom_range(4, 1);
               rsp_if.ready <= 1'b0;
            end else begin
               rsp_if.ready <= 1'b1;
            end
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // valid stays high into the next word when no gap is drawn
   task automatic send_word(input env_comp_pkg::func_type f, input logic [19:0] raw,
                            input bit gaps);
      int gap;
      gap = gaps ? $urandom_range(4, 0) : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.func <= f;
      req_if.raw_reading <= raw;
      do @(posedge clock); while (!req_if.ready);
      expected_q.push_back(compensate(f, raw));
      sent++;
      case (f)
         env_comp_pkg::FUNC_TEMP:  n_temp++;
         env_comp_pkg::FUNC_PRESS: n_press++;
         env_comp_pkg::FUNC_HUM:   n_hum++;
         default:                  n_none++;
      endcase
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [63:0] d);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data <= d;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      case (idx)
         env_comp_pkg::CSR_TEMP_CAL:    sh_temp_cal = d[47:0];
         env_comp_pkg::CSR_PRESS_CAL_A: sh_press_a = d;
         env_comp_pkg::CSR_PRESS_CAL_B: sh_press_b = d;
         env_comp_pkg::CSR_PRESS_CAL_C: sh_press_c = d[15:0];
         env_comp_pkg::CSR_HUM_CAL_A:   sh_hum_a = d[31:0];
         env_comp_pkg::CSR_HUM_CAL_B:   sh_hum_b = d[39:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // typical factory calibration, so results fall in the normal range
   task automatic load_typical();
      write_csr(env_comp_pkg::CSR_TEMP_CAL, {16'd0, 16'hFC18, 16'd26435, 16'd27504});
      write_csr(env_comp_pkg::CSR_PRESS_CAL_A, {16'd2855, 16'hD4E4, 16'hD0BA, 16'd36477});
      write_csr(env_comp_pkg::CSR_PRESS_CAL_B, {16'hF060, 16'h3C70, 16'hFFF9, 16'h008C});
      write_csr(env_comp_pkg::CSR_PRESS_CAL_C, 64'd6000);
      write_csr(env_comp_pkg::CSR_HUM_CAL_A, {32'd0, 8'd0, 16'd362, 8'd75});
      write_csr(env_comp_pkg::CSR_HUM_CAL_B, {24'd0, 8'd30, 16'd50, 16'd313});
   endtask

   task automatic load_random();
      write_csr(env_comp_pkg::CSR_TEMP_CAL, {$urandom, $urandom});
      write_csr(env_comp_pkg::CSR_PRESS_CAL_A, {$urandom, $urandom});
      write_csr(env_comp_pkg::CSR_PRESS_CAL_B, {$urandom, $urandom});
      write_csr(env_comp_pkg::CSR_PRESS_CAL_C, {$urandom, $urandom});
      write_csr(env_comp_pkg::CSR_HUM_CAL_A, {$urandom, $urandom});
      write_csr(env_comp_pkg::CSR_HUM_CAL_B, {$urandom, $urandom});
   endtask

   task automatic load_all(input logic [63:0] d);
      write_csr(env_comp_pkg::CSR_TEMP_CAL, d);
      write_csr(env_comp_pkg::CSR_PRESS_CAL_A, d);
      write_csr(env_comp_pkg::CSR_PRESS_CAL_B, d);
      write_csr(env_comp_pkg::CSR_PRESS_CAL_C, d);
      write_csr(env_comp_pkg::CSR_HUM_CAL_A, d);
      write_csr(env_comp_pkg::CSR_HUM_CAL_B, d);
   endtask

   // calibration at reset: fine temperature zero, zero P1 gives the zero divisor
   task automatic test_reset_defaults();
      send_word(env_comp_pkg::FUNC_PRESS, 20'd0, 1'b0);
      send_word(env_comp_pkg::FUNC_HUM, 20'hFFFFF, 1'b0);
      send_word(env_comp_pkg::FUNC_TEMP, 20'd0, 1'b0);
      send_word(env_comp_pkg::FUNC_NONE, 20'hFFFFF, 1'b0);
      drain();
   endtask

   // field extremes under typical and extreme calibration
   task automatic test_directed();
      load_typical();
      send_word(env_comp_pkg::FUNC_HUM, 20'd30000, 1'b0);
      send_word(env_comp_pkg::FUNC_TEMP, 20'd519888, 1'b0);
      send_word(env_comp_pkg::FUNC_PRESS, 20'd415148, 1'b0);
      send_word(env_comp_pkg::FUNC_HUM, 20'd30000, 1'b0);
      send_word(env_comp_pkg::FUNC_NONE, 20'd12345, 1'b0);
      send_word(env_comp_pkg::FUNC_PRESS, 20'd0, 1'b0);
      send_word(env_comp_pkg::FUNC_PRESS, 20'hFFFFF, 1'b0);
      send_word(env_comp_pkg::FUNC_HUM, 20'd0, 1'b0);
      send_word(env_comp_pkg::FUNC_HUM, 20'h0FFFF, 1'b0);
      send_word(env_comp_pkg::FUNC_TEMP, 20'hFFFFF, 1'b0);
      send_word(env_comp_pkg::FUNC_HUM, 20'hF0000, 1'b0);
      send_word(env_comp_pkg::FUNC_TEMP, 20'd0, 1'b0);
      send_word(env_comp_pkg::FUNC_PRESS, 20'd300000, 1'b0);
      drain();
      load_all(64'hFFFF_FFFF_FFFF_FFFF);
      send_word(env_comp_pkg::FUNC_TEMP, 20'hFFFFF, 1'b0);
      send_word(env_comp_pkg::FUNC_PRESS, 20'hFFFFF, 1'b0);
      send_word(env_comp_pkg::FUNC_HUM, 20'hFFFFF, 1'b0);
      send_word(env_comp_pkg::FUNC_TEMP, 20'd0, 1'b0);
      send_word(env_comp_pkg::FUNC_PRESS, 20'd0, 1'b0);
      drain();
      load_all(64'h8000_8000_8000_8000);
      send_word(env_comp_pkg::FUNC_TEMP, 20'h80000, 1'b0);
      send_word(env_comp_pkg::FUNC_PRESS, 20'h7FFFF, 1'b0);
      send_word(env_comp_pkg::FUNC_HUM, 20'h08000, 1'b0);
      drain();
   endtask

   // random readings, mostly measurement cycles: temperature, then the others
   task automatic test_random(input int n);
      int k;
      k = 0;
      while (k < n) begin
         if ($urandom_range(9, 0) < 8) begin
            send_word(env_comp_pkg::FUNC_TEMP, 20'($urandom), 1'b1);
            send_word(env_comp_pkg::FUNC_PRESS, 20'($urandom), 1'b1);
            send_word(env_comp_pkg::FUNC_HUM, 20'($urandom), 1'b1);
            k += 3;
         end else begin
            send_word(env_comp_pkg::func_type'($urandom_range(3, 0)), 20'($urandom), 1'b1);
            k++;
         end
      end
      drain();
   endtask

   initial begin
      sh_temp_cal = '0; sh_press_a = '0; sh_press_b = '0;
      sh_press_c = '0; sh_hum_a = '0; sh_hum_b = '0; sh_fine = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_directed();
      load_typical();
      test_random(400);
      rsp_stall_en = 1'b0;
      test_random(150);
      rsp_stall_en = 1'b1;
      repeat (4) begin
         load_random();
         test_random(150);
      end
      repeat (60) @(posedge clock);
      $display("covered %0d words: %0d temperature, %0d pressure, %0d humidity, %0d idle",
               sent, n_temp, n_press, n_hum, n_none);
      $display("typical, random, all-ones and sign-bit calibration; %0d results checked",
               received);
      if (errors == 0 && expected_q.size() == 0) begin
         $display("[env_sensor_compensation_core] OK");
      end else begin
         $display("[env_sensor_compensation_core] ERROR");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/env_comp_pkg.sv
rtl/core/env_comp_req_if.sv
rtl/core/env_comp_rsp_if.sv
rtl/core/env_comp_csr_if.sv
rtl/core/env_comp_mul.sv
rtl/core/env_comp_div.sv
rtl/core/env_sensor_compensation_core.sv
sim/env_sensor_compensation_core_test.sv
